// ----- design/idpcm_pkg.sv -----
// Shared types and constants for the 2D DPCM image codec.
package idpcm_pkg;

    localparam int PIX_W      = 8;
    localparam int RES_W      = 9;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    // Position of a pixel as the predictor sees it.
    typedef struct packed {
        t_mode mode;
        logic  row_nz;   // not the top row: pixel above exists
        logic  col_nz;   // not column 0: left pixel exists
    } t_pred_ctl;

endpackage

// ----- design/idpcm_in_if.sv -----
// Input pixel/residual channel.
interface idpcm_in_if;
    import idpcm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PIX_W-1:0]        pixel_in;
    logic signed [RES_W-1:0] residual_in;
    logic                    frame_start;

    modport source (output valid, output pixel_in, output residual_in,
                    output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input residual_in,
                    input frame_start, output ready);
endinterface

// ----- design/idpcm_out_if.sv -----
// Output residual/pixel channel.
interface idpcm_out_if;
    import idpcm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] residual_out;
    logic [PIX_W-1:0]        pixel_out;
    logic                    last_of_frame;

    modport source (output valid, output residual_out, output pixel_out,
                    output last_of_frame, input ready);
    modport sink   (input valid, input residual_out, input pixel_out,
                    input last_of_frame, output ready);
endinterface

// ----- design/idpcm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module idpcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/idpcm_pred.sv -----
// Predictor and encode/decode arithmetic for one pixel.
module idpcm_pred (
    input  idpcm_pkg::t_pred_ctl          i_ctl,
    input  logic [7:0]                    i_a,         // left
    input  logic [7:0]                    i_b_raw,     // line store read
    input  logic [7:0]                    i_c,         // above-left
    input  logic [7:0]                    i_pixel,
    input  logic signed [8:0]             i_residual,
    output logic [7:0]                    o_b,         // above, zero on top row
    output logic [7:0]                    o_pix,       // pixel to store
    output logic signed [8:0]             o_residual_out,
    output logic [7:0]                    o_pixel_out
);
    import idpcm_pkg::*;

    logic [PIX_W-1:0]        b;
    logic signed [RES_W-1:0] diff;
    logic signed [RES_W-1:0] diff_adj;
    logic signed [RES_W-1:0] half;
    logic signed [PIX_W+1:0] p;
    logic [PIX_W-1:0]        p_clamp;
    logic [PIX_W-1:0]        pred;
    logic [PIX_W-1:0]        pix;
    logic [RES_W-1:0]        res;

    always_comb begin
        b = i_ctl.row_nz ? i_b_raw : '0;

        // (B - C) / 2 truncated toward zero: bias negatives by one, then shift
        diff     = $signed({1'b0, b}) - $signed({1'b0, i_c});
        diff_adj = diff + $signed({8'd0, diff[RES_W-1]});
        half     = diff_adj >>> 1;
        p        = $signed({half[RES_W-1], half}) + $signed({2'b00, i_a});

        if (p[PIX_W+1]) begin
            p_clamp = '0;
        end else if (p[PIX_W]) begin
            p_clamp = PIX_MAX;
        end else begin
            p_clamp = p[PIX_W-1:0];
        end

        if (!i_ctl.row_nz) begin
            pred = i_ctl.col_nz ? i_a : '0;
        end else if (!i_ctl.col_nz) begin
            pred = b;
        end else begin
            pred = p_clamp;
        end

        if (i_ctl.mode == MODE_DECODE) begin
            pix = pred + i_residual[PIX_W-1:0];
            res = '0;
        end else begin
            pix = i_pixel;
            res = {1'b0, i_pixel} - {1'b0, pred};
        end
    end

    assign o_b            = b;
    assign o_pix          = pix;
    assign o_residual_out = $signed(res);
    assign o_pixel_out    = (i_ctl.mode == MODE_DECODE) ? pix : '0;
endmodule

// ----- design/image_dpcm_codec.sv -----
// Lossless 2D DPCM image codec: top level with position tracking and line store.
//
// Usage:
//   i_stream carries one pixel (encode) or one residual (decode) per
//   transaction in raster order; frame_start on a transaction forces it to
//   row 0, column 0. o_stream returns one transaction per input transaction,
//   in order: the residual in encode mode, the rebuilt pixel in decode mode,
//   with last_of_frame on the final pixel of the frame.
//   Configuration (mode, image_width, image_height) is written through
//   i_cfg_we/i_cfg_idx/i_cfg_data while the codec is empty.
// Timing:
//   Throughput is one transaction per cycle while the output is not stalled.
//   Accepting a transaction loads the read stage and issues the line store
//   read (registered RAM read port); the predictor runs on the read stage and
//   its result loads the result register. A same-address write/read in the
//   same cycle (width 1, frame restarts) is forwarded around the RAM.
// Reset (synchronous, active low): both stages empty, position at row 0
//   column 0, neighbors zero, registers at encode / 1024 / 1. The line store
//   is not cleared; top-row reads may see stale entries, which become zero.
// Stall: the result register holds while o_stream.ready is low; the middle
//   stage fills behind it, and i_stream.ready drops only when both are full.
module image_dpcm_codec #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [idpcm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [idpcm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    idpcm_in_if.sink                           i_stream,
    idpcm_out_if.source                        o_stream
);
    import idpcm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

    // configuration
    t_mode              r_mode;
    logic [IMG_W_W-1:0] r_width;
    logic [IMG_H_W-1:0] r_height;

    // position counters
    logic [CW-1:0]      r_col,  n_col;
    logic [IMG_H_W-1:0] r_row,  n_row;

    // neighbors
    logic [PIX_W-1:0]   r_left;
    logic [PIX_W-1:0]   r_above_left;

    // read stage
    logic                    r_s1_valid;
    logic [PIX_W-1:0]        r_s1_pixel;
    logic signed [RES_W-1:0] r_s1_residual;
    logic [CW-1:0]           r_s1_col;
    logic                    r_s1_row_nz;
    logic                    r_s1_last;
    logic                    r_fwd_hit;
    logic [PIX_W-1:0]        r_fwd_data;

    // result register
    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_out_residual;
    logic [PIX_W-1:0]        r_out_pixel;
    logic                    r_out_last;

    logic [WW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic [CW-1:0]      col0;
    logic [IMG_H_W:0]   row0;
    logic [CW-1:0]      cur_col;
    logic [IMG_H_W-1:0] cur_row;
    logic               cur_last;
    logic               accept;
    logic               s1_drain;

    logic [PIX_W-1:0]        ram_rdata;
    logic [PIX_W-1:0]        b_raw;
    logic [PIX_W-1:0]        b_used;
    logic [PIX_W-1:0]        pix;
    logic signed [RES_W-1:0] res_out;
    logic [PIX_W-1:0]        pix_out;
    t_pred_ctl               ctl;

    assign s1_drain        = r_s1_valid && (!r_out_valid || o_stream.ready);
    assign i_stream.ready  = !r_s1_valid || s1_drain;
    assign accept          = i_stream.valid && i_stream.ready;

    // effective frame size: width 0 acts as 1, above the store acts as full
    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height == '0) ? IMG_H_W'(1) : r_height;
    end

    // position of the accepted pixel and of the one after it
    always_comb begin
        col0 = i_stream.frame_start ? '0 : r_col;
        row0 = i_stream.frame_start ? '0 : {1'b0, r_row};
        if (WW'(col0) >= w_eff) begin
            col0 = '0;
            row0 = row0 + 1'b1;
        end
        if (row0 >= {1'b0, h_eff}) begin
            row0 = '0;
        end
        cur_col  = col0;
        cur_row  = row0[IMG_H_W-1:0];
        cur_last = (WW'(cur_col) == w_eff - 1'b1) && (cur_row == h_eff - 1'b1);

        if (WW'(cur_col) + 1'b1 >= w_eff) begin
            n_col = '0;
            n_row = ({1'b0, cur_row} + 1'b1 >= {1'b0, h_eff}) ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ENCODE;
            r_width  <= IMG_W_W'(1024);
            r_height <= IMG_H_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[0]);
                CFG_WIDTH:  r_width  <= i_cfg_data[IMG_W_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // counters advance on acceptance, neighbors on prediction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_above_left <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (s1_drain) begin
                r_left       <= pix;
                r_above_left <= b_used;
            end
            if (i_stream.ready) begin
                r_s1_valid <= i_stream.valid;
            end
            if (s1_drain) begin
                r_out_valid <= 1'b1;
            end else if (o_stream.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payload; forward the pixel written this cycle if it is the one read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel    <= i_stream.pixel_in;
            r_s1_residual <= i_stream.residual_in;
            r_s1_col      <= cur_col;
            r_s1_row_nz   <= (cur_row != '0);
            r_s1_last     <= cur_last;
            r_fwd_hit     <= s1_drain && (r_s1_col == cur_col);
            r_fwd_data    <= pix;
        end
        if (s1_drain) begin
            r_out_residual <= res_out;
            r_out_pixel    <= pix_out;
            r_out_last     <= r_s1_last;
        end
    end

    idpcm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_drain),
        .i_waddr (r_s1_col),
        .i_wdata (pix),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    assign b_raw      = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign ctl.mode   = r_mode;
    assign ctl.row_nz = r_s1_row_nz;
    assign ctl.col_nz = (r_s1_col != '0);

    idpcm_pred u_pred (
        .i_ctl          (ctl),
        .i_a            (r_left),
        .i_b_raw        (b_raw),
        .i_c            (r_above_left),
        .i_pixel        (r_s1_pixel),
        .i_residual     (r_s1_residual),
        .o_b            (b_used),
        .o_pix          (pix),
        .o_residual_out (res_out),
        .o_pixel_out    (pix_out)
    );

    assign o_stream.valid         = r_out_valid;
    assign o_stream.residual_out  = r_out_residual;
    assign o_stream.pixel_out     = r_out_pixel;
    assign o_stream.last_of_frame = r_out_last;
endmodule
